>>> hdl/quoted_escaped_tokenizer_core_assert.svh
// Assertion macros for the tokenizer core.
// Each use samples on clk_i and is disabled while rst_ni is low.
`ifndef QUOTED_ESCAPED_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_ESCAPED_TOKENIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define QET_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define QET_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`define QET_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define QET_ASSERT(label, prop)
`define QET_ASSERT_IMPLY(label, pre, post)
`define QET_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> hdl/qet_pkg.sv
`default_nettype none
package qet_pkg;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  typedef enum logic [2:0] {
    REG_KEEP_EMPTY   = 3'd0,
    REG_DELIM_COUNT  = 3'd1,
    REG_DELIM_FIRST  = 3'd2,
    REG_DELIM_SECOND = 3'd3,
    REG_DELIM_THIRD  = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam logic [1:0] DELIM_COUNT_RST  = 2'd3;
  localparam logic [7:0] DELIM_FIRST_RST  = 8'd44;
  localparam logic [7:0] DELIM_SECOND_RST = 8'd32;
  localparam logic [7:0] DELIM_THIRD_RST  = 8'd9;

  // Escape letters and the control bytes they stand for.
  function automatic logic [7:0] translate_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h61:   r = 8'h07; // a
      8'h62:   r = 8'h08; // b
      8'h65:   r = 8'h1B; // e
      8'h66:   r = 8'h0C; // f
      8'h6E:   r = 8'h0A; // n
      8'h72:   r = 8'h0D; // r
      8'h73:   r = 8'h20; // s
      8'h74:   r = 8'h09; // t
      8'h76:   r = 8'h0B; // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/qet_stream_if.sv
`default_nettype none
interface qet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_end;

  modport source (output valid, output char_in, output string_end, input ready);
  modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

interface qet_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       char_valid;
  logic       token_done;

  modport source (output valid, output token_char, output char_valid, output token_done,
                  input ready);
  modport sink   (input valid, input token_char, input char_valid, input token_done,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/quoted_escaped_tokenizer_core.sv
// Tokenizer core: splits a byte string into tokens at up to three delimiter bytes,
// removing quotes and translating backslash escapes outside quotes.
// in_i carries one string byte per transfer, or an end-of-string marker.
// out_o carries at most one result per input transfer: a token byte
// (char_valid) or an end of token (token_done), never both.
// Each input transfer lands in an input register; once the result register is free,
// one pass of logic updates the quote/escape/token state and loads the result register.
// Throughput: one input transfer per cycle while the sink takes results, with no
// result register bubble.
// When the sink stalls, the result register holds, then the input register
// holds, and in_i.ready drops only when both are full.
// Reset clears the pipeline and state and loads the delimiter registers with
// comma, space and tab, count 3, skip mode. Configure through the APB port
// (register i at byte address 4*i) only while the core is idle.
`default_nettype none
`include "quoted_escaped_tokenizer_core_assert.svh"
module quoted_escaped_tokenizer_core
  import qet_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qet_in_if.sink           in_i,
  qet_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // configuration registers
  logic       keep_q;
  logic [1:0] dcount_q;
  logic [7:0] dfirst_q, dsecond_q, dthird_q;
  cfg_reg_e   cfg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q    <= 1'b0;
      dcount_q  <= DELIM_COUNT_RST;
      dfirst_q  <= DELIM_FIRST_RST;
      dsecond_q <= DELIM_SECOND_RST;
      dthird_q  <= DELIM_THIRD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEEP_EMPTY:   keep_q    <= pwdata[0];
        REG_DELIM_COUNT:  dcount_q  <= pwdata[1:0];
        REG_DELIM_FIRST:  dfirst_q  <= pwdata[7:0];
        REG_DELIM_SECOND: dsecond_q <= pwdata[7:0];
        REG_DELIM_THIRD:  dthird_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEEP_EMPTY:   prdata = {31'd0, keep_q};
      REG_DELIM_COUNT:  prdata = {30'd0, dcount_q};
      REG_DELIM_FIRST:  prdata = {24'd0, dfirst_q};
      REG_DELIM_SECOND: prdata = {24'd0, dsecond_q};
      REG_DELIM_THIRD:  prdata = {24'd0, dthird_q};
      default:          prdata = 32'd0;
    endcase
  end

  // input register
  logic       in_vq, in_vd;
  logic [7:0] in_char_q;
  logic       in_end_q;
  logic       out_vq, out_vd;
  logic       out_free, proc;

  assign out_free   = !out_vq || out_o.ready;
  assign proc       = in_vq && out_free;
  assign in_i.ready = !in_vq || out_free;

  always_comb begin
    in_vd = in_vq;
    if (in_i.ready) begin
      in_vd = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else begin
      in_vq <= in_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_in;
      in_end_q  <= in_i.string_end;
    end
  end

  // token state
  quote_e quote_q, quote_d, quote_k;
  logic   esc_q, esc_d;
  logic   open_q, open_d;
  logic   is_delim;
  logic       res_v, res_cv, res_td;
  logic [7:0] res_char;

  assign is_delim = (dcount_q >= 2'd1 && in_char_q == dfirst_q)  ||
                    (dcount_q >= 2'd2 && in_char_q == dsecond_q) ||
                    (dcount_q == 2'd3 && in_char_q == dthird_q);
  assign quote_k  = (in_char_q == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;

  always_comb begin
    quote_d  = quote_q;
    esc_d    = esc_q;
    open_d   = open_q;
    res_v    = 1'b0;
    res_cv   = 1'b0;
    res_td   = 1'b0;
    res_char = 8'd0;
    priority if (in_end_q) begin
      // close the token; drop a dangling escape or an open quote
      quote_d = QUOTE_NONE;
      esc_d   = 1'b0;
      open_d  = keep_q;
      res_v   = keep_q || open_q;
      res_td  = keep_q || open_q;
    end else if (esc_q) begin
      esc_d    = 1'b0;
      open_d   = 1'b1;
      res_v    = 1'b1;
      res_cv   = 1'b1;
      res_char = (quote_q != QUOTE_NONE) ? in_char_q : translate_escape(in_char_q);
    end else if (in_char_q == CHAR_DQUOTE || in_char_q == CHAR_SQUOTE) begin
      quote_d = (quote_q == quote_k) ? QUOTE_NONE : quote_k;
      open_d  = 1'b1;
    end else if (in_char_q == CHAR_BSLASH) begin
      // inside quotes the backslash passes through
      esc_d    = 1'b1;
      open_d   = 1'b1;
      res_v    = (quote_q != QUOTE_NONE);
      res_cv   = (quote_q != QUOTE_NONE);
      res_char = (quote_q != QUOTE_NONE) ? in_char_q : 8'd0;
    end else if (quote_q == QUOTE_NONE && is_delim) begin
      open_d = keep_q;
      res_v  = keep_q || open_q;
      res_td = keep_q || open_q;
    end else begin
      open_d   = 1'b1;
      res_v    = 1'b1;
      res_cv   = 1'b1;
      res_char = in_char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= QUOTE_NONE;
      esc_q   <= 1'b0;
      open_q  <= 1'b0;
    end else if (proc) begin
      quote_q <= quote_d;
      esc_q   <= esc_d;
      open_q  <= open_d;
    end
  end

  // result register
  logic [7:0] out_char_q;
  logic       out_cv_q, out_td_q;

  always_comb begin
    out_vd = out_vq;
    if (out_free) begin
      out_vd = proc && res_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else begin
      out_vq <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_v) begin
      out_char_q <= res_char;
      out_cv_q   <= res_cv;
      out_td_q   <= res_td;
    end
  end

  assign out_o.valid      = out_vq;
  assign out_o.token_char = out_char_q;
  assign out_o.char_valid = out_cv_q;
  assign out_o.token_done = out_td_q;

  `QET_ASSERT_IMPLY(a_one_kind, out_vq, !(out_cv_q && out_td_q))
  `QET_ASSERT_IMPLY(a_done_zero_char, out_vq && !out_cv_q, out_td_q && out_char_q == 8'd0)
  `QET_ASSERT_NEXT(a_in_hold, in_vq && !out_free, in_vq && $stable(in_char_q) && $stable(in_end_q))
  `QET_ASSERT_NEXT(a_end_clears, proc && in_end_q, quote_q == QUOTE_NONE && !esc_q && open_q == keep_q)

endmodule
`default_nettype wire

>>> tb/sv/quoted_escaped_tokenizer_core_checker.sv
module quoted_escaped_tokenizer_core_checker
  import qet_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  qet_in_if           in_mon_i,
  qet_out_if          out_mon_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] chr;
    logic       chr_valid;
    logic       done;
  } tok_result_t;

  // Register copies, snooped from the configuration port
  logic       keep_mode;
  logic [1:0] delim_cnt;
  logic [7:0] delim_chr [3];

  // Tokenizer state
  quote_e     quote_st;
  logic       esc_st;
  logic       open_st;

  tok_result_t expected_tokens [$];
  int          fail_cnt = 0;

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "e":     return 8'h1B;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "s":     return 8'h20;
      "t":     return 8'h09;
      "v":     return 8'h0B;
      default: return c;
    endcase
  endfunction

  function automatic logic is_delimiter(input logic [7:0] c);
    for (int i = 0; i < 3; i++) begin
      if (i < int'(delim_cnt) && c == delim_chr[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the tokenizer by one byte or end marker; return 1 when a result is due
  function automatic logic tokenize_byte(input logic [7:0] c, input logic eos,
                                         output tok_result_t res);
    logic   close;
    quote_e kind;
    res = '0;
    if (eos) begin
      close = keep_mode || open_st;
      quote_st = QUOTE_NONE;
      esc_st = 1'b0;
      open_st = keep_mode;
      res.done = 1'b1;
      return close;
    end
    if (esc_st) begin
      esc_st = 1'b0;
      open_st = 1'b1;
      res.chr = (quote_st != QUOTE_NONE) ? c : unescape(c);
      res.chr_valid = 1'b1;
      return 1'b1;
    end
    if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
      kind = (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
      quote_st = (quote_st == kind) ? QUOTE_NONE : kind;
      open_st = 1'b1;
      return 1'b0;
    end
    if (c == CHAR_BSLASH) begin
      esc_st = 1'b1;
      open_st = 1'b1;
      if (quote_st != QUOTE_NONE) begin
        res.chr = c;
        res.chr_valid = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (quote_st == QUOTE_NONE && is_delimiter(c)) begin
      close = keep_mode || open_st;
      open_st = keep_mode;
      res.done = 1'b1;
      return close;
    end
    open_st = 1'b1;
    res.chr = c;
    res.chr_valid = 1'b1;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tok_result_t want;
    tok_result_t next_res;
    if (!rst_ni) begin
      keep_mode    = 1'b0;
      delim_cnt    = DELIM_COUNT_RST;
      delim_chr[0] = DELIM_FIRST_RST;
      delim_chr[1] = DELIM_SECOND_RST;
      delim_chr[2] = DELIM_THIRD_RST;
      quote_st     = QUOTE_NONE;
      esc_st       = 1'b0;
      open_st      = 1'b0;
      expected_tokens.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_KEEP_EMPTY:   keep_mode = pwdata[0];
          REG_DELIM_COUNT:  delim_cnt = pwdata[1:0];
          REG_DELIM_FIRST:  delim_chr[0] = pwdata[7:0];
          REG_DELIM_SECOND: delim_chr[1] = pwdata[7:0];
          REG_DELIM_THIRD:  delim_chr[2] = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_tokens.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual char %h valid %b done %b",
                   $time, out_mon_i.token_char, out_mon_i.char_valid, out_mon_i.token_done);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_char", want.chr, out_mon_i.token_char);
          check_field("char_valid", 8'(want.chr_valid), 8'(out_mon_i.char_valid));
          check_field("token_done", 8'(want.done), 8'(out_mon_i.token_done));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (tokenize_byte(in_mon_i.char_in, in_mon_i.string_end, next_res))
          expected_tokens.push_back(next_res);
      end
      pending_o    <= expected_tokens.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

>>> tb/sv/quoted_escaped_tokenizer_core_tb.sv
module quoted_escaped_tokenizer_core_tb;
  import qet_pkg::*;

  localparam int          CYCLE      = 20;
  localparam int          MAX_CYCLES = 500000;
  localparam logic [2:0]  REG_SPARE  = 3'd5;  // no register lives here
  localparam int          PHASES     = 12;
  localparam int          PHASE_ITEMS = 150;
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic       keep;
    logic [1:0] count;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
  } setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count;
  int          pending;

  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  delim_set [3];

  setting_t corner_cfgs [6] = '{
    '{1'b0, 2'd3, 8'd44,  8'd32,  8'd9},
    '{1'b1, 2'd1, 8'd1,   8'd255, 8'd9},
    '{1'b0, 2'd0, 8'd44,  8'd32,  8'd9},
    '{1'b1, 2'd3, 8'd0,   8'd255, 8'd32},
    '{1'b0, 2'd2, 8'd255, 8'd1,   8'd0},
    '{1'b1, 2'd2, 8'd59,  8'd32,  8'd124}
  };

  qet_in_if  in_bus ();
  qet_out_if out_bus ();

  always #(CYCLE / 2) clk_i = ~clk_i;

  quoted_escaped_tokenizer_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  quoted_escaped_tokenizer_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_bus),
    .out_mon_i    (out_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int draw_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 17)) : 0;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'("a") + 8'($urandom_range(0, 25));
    if (r < 45) return delim_set[$urandom_range(0, 2)];
    if (r < 53) return r[0] ? CHAR_DQUOTE : CHAR_SQUOTE;
    if (r < 60) return CHAR_BSLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eos);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.char_in    <= c;
    in_bus.string_end <= eos;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic end_string();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    end_string();
  endtask

  task automatic send_random_string(inout int sent);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) send_item(pick_byte(), 1'b0);
    end_string();
    sent += len + 1;
  endtask

  // Drop valid, let every expected result drain, then cover the no-result tail
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input setting_t s);
    settle();
    write_reg(REG_KEEP_EMPTY, 32'(s.keep));
    write_reg(REG_DELIM_COUNT, 32'(s.count));
    write_reg(REG_DELIM_FIRST, 32'(s.d1));
    write_reg(REG_DELIM_SECOND, 32'(s.d2));
    write_reg(REG_DELIM_THIRD, 32'(s.d3));
    delim_set[0] = s.d1;
    delim_set[1] = s.d2;
    delim_set[2] = s.d3;
  endtask

  initial begin
    #(CYCLE * MAX_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
    end
  end

  initial begin : stimulus
    setting_t s;
    int       sent;
    in_bus.valid      = 1'b0;
    in_bus.char_in    = 8'h00;
    in_bus.string_end = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    delim_set[0] = DELIM_FIRST_RST;
    delim_set[1] = DELIM_SECOND_RST;
    delim_set[2] = DELIM_THIRD_RST;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Skip mode from reset: delimiter-only string, escapes, quote switching,
    // dangling backslash in an open quote, extreme bytes, empty quoted token
    send_string(",,");
    send_string("\\n' \\y\"z\\");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    end_string();
    send_string("\"\",");

    // Keep mode: empty string still gives a token, each delimiter ends one
    settle();
    write_reg(REG_KEEP_EMPTY, 32'd1);
    send_string("");
    send_string(",a,");

    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        s = corner_cfgs[p];
      end else begin
        s.keep  = 1'($urandom_range(0, 1));
        s.count = 2'($urandom_range(0, 3));
        s.d1    = 8'($urandom_range(0, 255));
        s.d2    = 8'($urandom_range(0, 255));
        s.d3    = 8'($urandom_range(0, 255));
      end
      apply_settings(s);
      if (p == 0) write_reg(REG_SPARE, 32'hFF);
      quiet = (p % 4 == 3);

      if (p == 4) begin
        // Hold the result side off while bytes keep arriving back to back
        quiet = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_item(8'("a") + 8'($urandom_range(0, 25)), 1'b0);
        end_string();
        quiet = 1'b0;
      end

      sent = 0;
      while (sent < PHASE_ITEMS) send_random_string(sent);
      // Now and then leave a string open so the next settings land mid-string
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_item(pick_byte(), 1'b0);
    end
    end_string();

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
